// ===== src/eemi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package eemi_pkg;

  // Default operand width; the request fields below are fixed at 32 bits.
  localparam int EEMI_WIDTH = 32;
  localparam int FIELD_W    = 32;

  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_NOT_COPRIME = 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] modulus;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] inverse;
    logic               status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new request
    logic start_div;  // clear the divider for a new quotient
    logic div_step;   // one restoring-division bit
    logic update;     // retire one Euclid iteration
    logic out_load;   // capture the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_zero;
    logic rc_zero;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/eemi_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module eemi_dp
  import eemi_pkg::*;
#(
  parameter int WIDTH = EEMI_WIDTH
) (
  input  wire logic clk,
  input  wire in_t  in_data,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output out_t      out_data
);

  logic [WIDTH-1:0] mod_r;
  logic [WIDTH-1:0] rem_prev_r, rem_prev_nxt;
  logic [WIDTH-1:0] rem_cur_r, rem_cur_nxt;
  logic [WIDTH:0]   coef_prev_r, coef_prev_nxt;
  logic [WIDTH:0]   coef_cur_r, coef_cur_nxt;
  logic [WIDTH-1:0] dvd_r, dvd_nxt;
  logic [WIDTH-1:0] part_r, part_nxt;
  logic [WIDTH:0]   acc_r, acc_nxt;
  out_t             out_r, out_nxt;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   trial_diff;
  logic             qbit;

  logic [WIDTH-1:0] mag;
  logic [WIDTH:0]   neg_c;
  logic [WIDTH-1:0] red;
  logic [WIDTH-1:0] inv_w;
  logic             not_coprime;

  // One restoring-division step; the quotient bit is folded straight into
  // the running product quotient * coef_cur by Horner's rule, MSB first.
  // Arithmetic wraps at WIDTH+1 bits, which is exact for the new coefficient.
  always_comb begin
    trial      = {part_r, dvd_r[WIDTH-1]};
    trial_diff = trial - {1'b0, rem_cur_r};
    qbit       = (trial >= {1'b0, rem_cur_r});
  end

  always_comb begin
    rem_prev_nxt  = rem_prev_r;
    rem_cur_nxt   = rem_cur_r;
    coef_prev_nxt = coef_prev_r;
    coef_cur_nxt  = coef_cur_r;
    dvd_nxt       = dvd_r;
    part_nxt      = part_r;
    acc_nxt       = acc_r;
    if (cmd.load) begin
      rem_prev_nxt  = WIDTH'(in_data.modulus);
      rem_cur_nxt   = WIDTH'(in_data.value);
      coef_prev_nxt = '0;
      coef_cur_nxt  = (WIDTH+1)'(1);
    end else if (cmd.start_div) begin
      dvd_nxt  = rem_prev_r;
      part_nxt = '0;
      acc_nxt  = '0;
    end else if (cmd.div_step) begin
      dvd_nxt  = {dvd_r[WIDTH-2:0], 1'b0};
      part_nxt = qbit ? trial_diff[WIDTH-1:0] : trial[WIDTH-1:0];
      acc_nxt  = {acc_r[WIDTH-1:0], 1'b0} + (qbit ? coef_cur_r : '0);
    end else if (cmd.update) begin
      rem_prev_nxt  = rem_cur_r;
      rem_cur_nxt   = part_r;
      coef_prev_nxt = coef_cur_r;
      coef_cur_nxt  = coef_prev_r - acc_r;
    end
  end

  // Final reduction of coef_prev into [0, modulus). Its magnitude never
  // exceeds the modulus, so one compare and subtract is enough.
  always_comb begin
    neg_c       = -coef_prev_r;
    mag         = coef_prev_r[WIDTH] ? neg_c[WIDTH-1:0] : coef_prev_r[WIDTH-1:0];
    red         = (mag >= mod_r) ? (mag - mod_r) : mag;
    inv_w       = (coef_prev_r[WIDTH] && (red != '0)) ? (mod_r - red) : red;
    not_coprime = (mod_r == '0) || (rem_prev_r != WIDTH'(1));
    out_nxt     = out_r;
    if (cmd.out_load) begin
      out_nxt.status  = not_coprime ? STATUS_NOT_COPRIME : STATUS_OK;
      out_nxt.inverse = not_coprime ? '0 : FIELD_W'(inv_w);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_r <= WIDTH'(in_data.modulus);
    end
    rem_prev_r  <= rem_prev_nxt;
    rem_cur_r   <= rem_cur_nxt;
    coef_prev_r <= coef_prev_nxt;
    coef_cur_r  <= coef_cur_nxt;
    dvd_r       <= dvd_nxt;
    part_r      <= part_nxt;
    acc_r       <= acc_nxt;
    out_r       <= out_nxt;
  end

  assign sts.mod_zero = (mod_r == '0);
  assign sts.rc_zero  = (rem_cur_r == '0);
  assign out_data     = out_r;

endmodule

`default_nettype wire

// ===== src/eemi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module eemi_ctrl
  import eemi_pkg::*;
#(
  parameter int WIDTH = EEMI_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_UPD   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.mod_zero || sts.rc_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.start_div = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(WIDTH - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/extended_euclid_mod_inverse.sv =====
// Modular inverse by the extended Euclidean algorithm. Each request carries a
// value and a modulus, both taken modulo 2^WIDTH, and produces exactly one
// result: the inverse of value in [0, modulus) with status ok, or inverse
// zero with status not_coprime when the gcd is not one or the modulus is zero.
// A modulus of one gives inverse zero with status ok. One request is worked
// on at a time. Each Euclid iteration runs a restoring divider one quotient
// bit per cycle; a request takes k iterations, where k is at most about
// 1.44 * WIDTH. A zero modulus or zero value finishes without any division.
// The result sits in an output register, so a new request is taken as soon
// as the previous one has been handed to that register.
`timescale 1ns / 1ps
`default_nettype none

module extended_euclid_mod_inverse
  import eemi_pkg::*;
#(
  parameter int WIDTH = EEMI_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  // The controller sequences load, per-bit division, iteration update and
  // result capture; the datapath holds the remainder and coefficient pairs.
  cmd_t cmd;
  sts_t sts;

  eemi_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  eemi_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk     (clk),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

`default_nettype wire

// ===== sim/tb_extended_euclid_mod_inverse.sv =====
`timescale 1ns / 1ps

module tb_extended_euclid_mod_inverse;
  import eemi_pkg::*;

  // Number of random requests that follow the directed ones.
  localparam int N_RANDOM = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Request side. The driver presents these at the falling edge.
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;

  // Result side. Ready also changes at the falling edge only.
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Requests waiting to be presented, and the results that accepted
  // requests are owed, oldest first.
  in_t  pending_reqs[$];
  out_t expected_inv[$];
  out_t want_res;

  int unsigned n_queued = 0;
  int unsigned n_total = 0;
  int unsigned req_issued = 0;
  int unsigned req_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;

  extended_euclid_mod_inverse uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expected result of one request, worked out with signed 64-bit
  // coefficients. In the extended Euclid recurrence the coefficients stay
  // within plus or minus the modulus, so nothing here can overflow.
  function automatic out_t inverse_of(in_t req);
    longint unsigned rp;
    longint unsigned rc;
    longint unsigned quo;
    longint unsigned rem;
    longint unsigned m;
    longint unsigned mag;
    longint sp;
    longint sc;
    longint sn;
    out_t res;
    res.inverse = '0;
    res.status = STATUS_NOT_COPRIME;
    m = req.modulus;
    // A zero modulus is refused before any division is attempted.
    if (m == 0) return res;
    rp = m;
    rc = req.value;
    sp = 0;
    sc = 1;
    while (rc != 0) begin
      quo = rp / rc;
      rem = rp % rc;
      sn = sp - $signed(quo) * sc;
      rp = rc;
      rc = rem;
      sp = sc;
      sc = sn;
    end
    // Only a gcd of one yields an inverse. A modulus of one always lands
    // here with a coefficient that reduces to zero.
    if (rp == 1) begin
      if (sp < 0) begin
        mag = longint'(-sp) % m;
        res.inverse = (mag == 0) ? '0 : FIELD_W'(m - mag);
      end else begin
        res.inverse = FIELD_W'(longint'(sp) % m);
      end
      res.status = STATUS_OK;
    end
    return res;
  endfunction

  // Idle bursts are left out in stretches of ten requests out of every
  // fifty, and entirely over the last forty requests of the run.
  function automatic bit idle_allowed();
    if (req_accepted + 40 >= n_total) return 1'b0;
    return (req_accepted % 50) >= 10;
  endfunction

  task automatic queue_req(input logic [FIELD_W-1:0] v, input logic [FIELD_W-1:0] m);
    in_t req;
    req.value = v;
    req.modulus = m;
    pending_reqs.push_back(req);
    n_queued++;
  endtask

  // Request driver. A request counts as taken once the acceptance counter
  // has caught up with the issue counter; until then valid and the payload
  // are held. Between requests the driver may start an idle burst.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && req_accepted != req_issued)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_reqs.size() > 0 && idle_allowed() &&
                   $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        in_gap = $urandom_range(0, 17);
      end else if (pending_reqs.size() > 0) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        req_issued++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure: ready drops in random bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap--;
    end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      out_gap = $urandom_range(0, 17);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor. Both handshakes are seen at the rising edge, where the
  // testbench inputs are settled and the block's outputs still hold their
  // pre-edge values. Each accepted request adds one expected result; each
  // accepted result is checked against the oldest one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_inv.push_back(inverse_of(in_data));
        req_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_inv.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: inverse=%h status=%b",
                     out_data.inverse, out_data.status);
        end else begin
          want_res = expected_inv.pop_front();
          if (out_data.inverse !== want_res.inverse ||
              out_data.status !== want_res.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected inverse=%h status=%b, got inverse=%h status=%b",
                       want_res.inverse, want_res.status,
                       out_data.inverse, out_data.status);
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [FIELD_W-1:0] v;
    logic [FIELD_W-1:0] m;
    logic [FIELD_W-1:0] g;

    // Directed requests: zero modulus, modulus one, zero value, a value
    // equal to or above the modulus, shared factors, the largest fields,
    // and a pair of adjacent Fibonacci numbers that needs the most steps.
    queue_req(32'd0, 32'd0);
    queue_req(32'd5, 32'd0);
    queue_req(32'hFFFF_FFFF, 32'd0);
    queue_req(32'd0, 32'd1);
    queue_req(32'd123, 32'd1);
    queue_req(32'hFFFF_FFFF, 32'd1);
    queue_req(32'd0, 32'd7);
    queue_req(32'd0, 32'hFFFF_FFFF);
    queue_req(32'd3, 32'd7);
    queue_req(32'd10, 32'd7);
    queue_req(32'd7, 32'd7);
    queue_req(32'd6, 32'd9);
    queue_req(32'd1, 32'd2);
    queue_req(32'd1, 32'hFFFF_FFFF);
    queue_req(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    queue_req(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    queue_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(32'd1836311903, 32'd2971215073);
    queue_req(32'd2971215073, 32'd1836311903);
    queue_req(32'd2, 32'd4294967291);
    queue_req(32'h8000_0000, 32'hFFFF_FFFF);
    queue_req(32'h5555_5555, 32'hAAAA_AAAA);
    n_total = n_queued + N_RANDOM;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int half = 0; half < 2; half++) begin
      // The sender holds off here until every owed result has arrived.
      while (req_accepted < n_queued || expected_inv.size() != 0) @(posedge clk);
      for (int k = 0; k < N_RANDOM / 2; k++) begin
        v = $urandom;
        m = $urandom;
        case ($urandom_range(0, 9))
          0, 1, 2: ;
          3: begin
            m = $urandom_range(1, 300);
            v = $urandom_range(0, 600);
          end
          4: begin
            // Shared factor, so the gcd is at least g.
            g = $urandom_range(2, 1000);
            m = g * $urandom_range(1, 4000000);
            v = g * $urandom_range(0, 4000000);
          end
          5: m = m >> $urandom_range(0, 31);
          6: begin
            case ($urandom_range(0, 4))
              0: m = 32'd0;
              1: m = 32'd1;
              2: m = 32'd2;
              3: m = 32'hFFFF_FFFF;
              default: m = 32'h8000_0000;
            endcase
            case ($urandom_range(0, 3))
              0: v = 32'd0;
              1: v = 32'hFFFF_FFFF;
              default: ;
            endcase
          end
          7: m = m | 32'd1;
          8: begin
            // Adjacent integers are always coprime.
            if (v == 32'hFFFF_FFFF) v = v - 1;
            if ($urandom_range(0, 1) == 0) m = v + 1;
            else begin
              m = v;
              v = v + 1;
            end
          end
          default: m = 32'd1 << $urandom_range(0, 31);
        endcase
        queue_req(v, m);
      end
    end

    // Wait for every request to be taken and every result to come back,
    // then give the block a little longer to show any stray result.
    while (req_accepted < n_total || expected_inv.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // The slowest legal run is well under 3 ms; this leaves ample margin.
  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
src/eemi_pkg.sv
src/eemi_dp.sv
src/eemi_ctrl.sv
src/extended_euclid_mod_inverse.sv
sim/tb_extended_euclid_mod_inverse.sv
